@@ rtl/wbps_pkg.sv @@
// Shared constants for the wildcard byte pattern search block.
`default_nettype none

package wbps_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Fixed widths of the ports
    localparam int PAT_BYTES  = 16;
    localparam int PLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int OFFSET_W   = 32;

    // Pattern byte that matches any text byte ('?')
    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Bytes of the configured pattern, byte i at element i
    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

endpackage

`default_nettype wire

@@ rtl/wbps_match.sv @@
// Full window compare of the byte window against the wildcard pattern.
`default_nettype none

module wbps_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  var logic [PATTERN_MAX-1:0][7:0] i_window,   // element 0 is the newest byte
    input  var t_pattern                    i_pattern,
    input  var logic [PLEN_W-1:0]           i_length,   // already clamped to PATTERN_MAX
    output var logic                        o_match
);

    logic mismatch;

    // Pattern byte i lines up with window element length-1-i
    always_comb begin
        mismatch = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if ((PLEN_W'(i + j + 1) == i_length) &&
                    (i_pattern[i] != WILDCARD_BYTE) &&
                    (i_pattern[i] != i_window[j])) begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    // Empty pattern never matches
    assign o_match = (i_length != '0) && !mismatch;

endmodule

`default_nettype wire

@@ rtl/wildcard_byte_pattern_search.sv @@
// Top level of the wildcard byte pattern search block.
`default_nettype none

// Takes one text word per cycle and reports the offset of the first byte of
// the leftmost place where the configured pattern (up to PATTERN_MAX bytes,
// 0x3F matches any byte) matches the stream. Each accepted word shifts a window of the last
// PATTERN_MAX bytes and is compared against the whole pattern in the same
// cycle; the result lands in a single output register and is visible after the
// accepting edge. Throughput is one word per cycle, set by the combinational
// window compare; input ready drops only in reset or while a result is held
// in the output register and not taken. A region gives exactly one result:
// found at the first match, or not found on the word marked last. Words after
// a match are taken and dropped until the last word, which clears the window
// and the position count. The count saturates at 2^OFFSET_BITS-1; the offset
// reported is the low 32 bits of the count less the pattern length. Write the
// pattern registers only while the block is idle.
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    // configuration
    input  var logic                  i_cfg_we,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  var logic [CFG_DATA_W-1:0] i_cfg_data,
    // text words
    input  var logic                  i_in_valid,
    output var logic                  o_in_ready,
    input  var logic [7:0]            i_text_byte,
    input  var logic                  i_last,
    // results
    output var logic                  o_out_valid,
    input  var logic                  i_out_ready,
    output var logic                  o_found,
    output var logic [OFFSET_W-1:0]   o_match_offset
);

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PLEN_W-1:0]      LEN_MAX   = PLEN_W'(PATTERN_MAX);

    // Configuration registers
    logic [63:0]       r_pat_low;
    logic [63:0]       r_pat_high;
    logic [PLEN_W-1:0] r_pat_len;

    // Region state
    logic [PATTERN_MAX-1:0][7:0] r_window;
    logic [PATTERN_MAX-1:0][7:0] n_window;
    logic [OFFSET_BITS-1:0]      r_count;
    logic [OFFSET_BITS-1:0]      n_count;
    logic                        r_reported;

    // Result register
    logic                r_out_valid;
    logic                r_found;
    logic [OFFSET_W-1:0] r_offset;

    logic                            accept;
    logic                            saturated;
    logic [PLEN_W-1:0]               active_len;
    logic                            window_match;
    logic                            hit;
    logic                            has_result;
    logic [OFFSET_BITS-1:0]          offset_full;
    logic [OFFSET_BITS+OFFSET_W-1:0] offset_ext;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= PLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                REG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept while the result slot is free or draining
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Shift the new byte into the window
    always_comb begin
        n_window[0] = i_text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // Advance the position count, holding at saturation
    assign saturated = (r_count == COUNT_MAX);
    assign n_count   = saturated ? r_count : r_count + OFFSET_BITS'(1);

    // Clamp an over-long pattern length
    assign active_len = (r_pat_len > LEN_MAX) ? LEN_MAX : r_pat_len;

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_window  (n_window),
        .i_pattern ({r_pat_high, r_pat_low}),
        .i_length  (active_len),
        .o_match   (window_match)
    );

    assign hit = !r_reported && !saturated && window_match &&
                 (n_count >= OFFSET_BITS'(active_len));
    assign has_result = !r_reported && (hit || i_last);

    // Offset of the first matched byte, low 32 bits
    assign offset_full = n_count - OFFSET_BITS'(active_len);
    assign offset_ext  = {{OFFSET_W{1'b0}}, offset_full};

    // Update region state; the last word clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_count    <= '0;
            r_reported <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_window   <= '0;
                r_count    <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_window   <= n_window;
                r_count    <= n_count;
                r_reported <= hit;
            end
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_result) begin
            r_found  <= hit;
            r_offset <= hit ? offset_ext[OFFSET_W-1:0] : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

endmodule

`default_nettype wire

@@ rtl/wbps_checker.sv @@
// Port-level checks of the wildcard byte pattern search block, bound to the top.
`default_nettype none

module wbps_checker
    import wbps_pkg::*;
(
    input var logic                  i_clk,
    input var logic                  i_rst_n,
    input var logic                  i_in_valid,
    input var logic                  o_in_ready,
    input var logic                  o_out_valid,
    input var logic                  i_out_ready,
    input var logic                  o_found,
    input var logic [OFFSET_W-1:0]   o_match_offset
);

    // Result slot is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A free result slot never stalls the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result slot");

    // A not-found word carries a zero offset
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_offset == '0))
        else $error("not-found word with nonzero offset");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found) && $stable(o_match_offset)))
        else $error("stalled result word changed");

    // A word only appears after an accepted input word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result word without an input word");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);

`default_nettype wire

@@ test/tb_wildcard_byte_pattern_search.sv @@
// Self-checking testbench for the wildcard byte pattern search block.
module tb_wildcard_byte_pattern_search;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned RANDOM_BYTES  = 1250;
    localparam int unsigned QUIET_BYTES   = 200;
    localparam int unsigned PHASE_BYTES   = 100;
    localparam int unsigned MAX_REGION    = 48;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [OFFSET_W-1:0]  COUNT_MAX  = '1;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } t_search_result;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte = '0;
    logic                  i_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [OFFSET_W-1:0]   o_match_offset;

    // Search state mirrored by the predictor
    t_pattern              pattern;
    logic [PLEN_W-1:0]     pattern_len;
    logic [7:0]            window_bytes [PAT_BYTES];
    logic [OFFSET_W-1:0]   byte_count;
    bit                    match_done;

    t_search_result        expected_results [$];

    // Run control and bookkeeping
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned regions_sent = 0;
    int unsigned found_seen = 0;
    int unsigned notfound_seen = 0;
    int unsigned settings_used = 1;

    wildcard_byte_pattern_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset)
    );

    always #5 i_clk = ~i_clk;

    // Clear the window and the position count for a new region
    function automatic void clear_region();
        for (int k = 0; k < PAT_BYTES; k++) window_bytes[k] = 8'h00;
        byte_count = '0;
        match_done = 1'b0;
    endfunction

    // Shift one text byte into the window and queue the result it causes
    function automatic void predict_search(input logic [7:0] value, input logic is_last);
        int unsigned    len;
        bit             saturated;
        bit             hit;
        t_search_result res;
        if (!match_done) begin
            len = (pattern_len > PAT_BYTES) ? PAT_BYTES : pattern_len;
            saturated = (byte_count == COUNT_MAX);
            for (int k = PAT_BYTES - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
            window_bytes[0] = value;
            if (!saturated) byte_count++;
            hit = !saturated && len != 0 && byte_count >= len;
            for (int i = 0; i < len; i++) begin
                if (pattern[i] != WILDCARD_BYTE && pattern[i] != window_bytes[len-1-i])
                    hit = 1'b0;
            end
            if (hit) begin
                res.found  = 1'b1;
                res.offset = byte_count - OFFSET_W'(len);
                expected_results.push_back(res);
                match_done = 1'b1;
            end else if (is_last) begin
                res.found  = 1'b0;
                res.offset = '0;
                expected_results.push_back(res);
            end
        end
        if (is_last) clear_region();
    endfunction

    // Offer one word, wait for the handshake, then predict its result
    task automatic send_text_byte(input logic [7:0] value, input logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= value;
        i_last      <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_search(value, is_last);
        bytes_sent++;
        if (is_last) regions_sent++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_PATTERN_LOW:    pattern[7:0] = value;
            REG_PATTERN_HIGH:   pattern[15:8] = value;
            REG_PATTERN_LENGTH: pattern_len = value[PLEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_pattern(input logic [63:0] low_word, input logic [63:0] high_word,
                               input logic [PLEN_W-1:0] len);
        write_reg(REG_PATTERN_LOW, low_word);
        write_reg(REG_PATTERN_HIGH, high_word);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        settings_used++;
    endtask

    // Random pattern word, about a quarter of the bytes wildcards
    function automatic logic [63:0] random_pattern_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD_BYTE : 8'($urandom);
        return w;
    endfunction

    // Text bytes lean toward pattern bytes and the edge values
    function automatic logic [7:0] pick_text_byte();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        if (sel == 0) return pattern[$urandom_range(0, PAT_BYTES - 1)];
        else if (sel == 1) return 8'h00;
        else if (sel == 2) return 8'hFF;
        else if (sel == 3) return WILDCARD_BYTE;
        else return 8'($urandom);
    endfunction

    // Build one region, mostly with the pattern planted, and send it
    task automatic send_region();
        logic [7:0]  region_bytes [MAX_REGION];
        int unsigned eff;
        int unsigned n;
        int unsigned pos;
        eff = (pattern_len > PAT_BYTES) ? PAT_BYTES : pattern_len;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 40);
        else n = $urandom_range((eff > 0) ? eff : 1, eff + 8);
        for (int i = 0; i < n; i++) region_bytes[i] = pick_text_byte();
        if (eff > 0 && n >= eff && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, n - eff);
            for (int i = 0; i < eff; i++)
                region_bytes[pos+i] = (pattern[i] == WILDCARD_BYTE) ? 8'($urandom) : pattern[i];
            // break the planted copy now and then
            if ($urandom_range(0, 3) == 0)
                region_bytes[pos + $urandom_range(0, eff - 1)] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < n; i++) send_text_byte(region_bytes[i], i == n - 1);
    endtask

    // Reset pattern is one zero byte
    task automatic test_defaults();
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h00, 1'b1);
    endtask

    // Wildcard in the middle; bytes after the match and the last word are dropped
    task automatic test_match_and_skip();
        wait_idle();
        set_pattern(64'h0000_0000_00FF_3F41, 64'h0, 5'd3);
        send_text_byte(8'h41, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h41, 1'b0);
        send_text_byte(8'h7E, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h12, 1'b0);
        send_text_byte(8'h55, 1'b1);
    endtask

    // Region ends before the pattern could fit
    task automatic test_short_region();
        send_text_byte(8'h41, 1'b0);
        send_text_byte(WILDCARD_BYTE, 1'b1);
    endtask

    // Match lands on the last word: only the found result
    task automatic test_match_on_last();
        send_text_byte(8'h41, 1'b0);
        send_text_byte(8'h99, 1'b0);
        send_text_byte(8'hFF, 1'b1);
    endtask

    task automatic test_empty_pattern();
        wait_idle();
        set_pattern(64'h0, 64'h0, 5'd0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h00, 1'b1);
    endtask

    // New pattern written between two words of one region
    task automatic test_config_mid_region();
        wait_idle();
        set_pattern(64'h10, 64'h0, 5'd1);
        send_text_byte(8'h20, 1'b0);
        wait_idle();
        set_pattern(64'h2120, 64'h0, 5'd2);
        send_text_byte(8'h21, 1'b1);
    endtask

    // Receiver holds off while every word makes a result
    task automatic test_backpressure();
        wait_idle();
        set_pattern({56'h0, WILDCARD_BYTE}, 64'h0, 5'd1);
        hold_req = 1'b1;
        for (int i = 0; i < 48; i++) send_text_byte(8'($urandom), 1'b1);
    endtask

    task automatic test_random_regions();
        int unsigned phase;
        int unsigned stop_at;
        int unsigned phase_end;
        logic [PLEN_W-1:0] len;
        phase = 0;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            wait_idle();
            if (bytes_sent + QUIET_BYTES >= stop_at) idle_on = 1'b0;
            case (phase)
                0: set_pattern('1, '1, 5'd16);
                1: set_pattern(random_pattern_word(), random_pattern_word(), 5'd0);
                2: set_pattern(random_pattern_word(), random_pattern_word(), 5'd31);
                3: set_pattern(random_pattern_word(), random_pattern_word(), 5'd17);
                4: set_pattern('0, '0, 5'd1);
                default: begin
                    if (phase == 5) write_reg(REG_UNUSED, 64'($urandom) << 32 | 64'($urandom));
                    if ($urandom_range(0, 7) == 0) len = 5'($urandom_range(0, 31));
                    else if ($urandom_range(0, 5) == 0) len = 5'd16;
                    else len = 5'($urandom_range(1, 6));
                    set_pattern(random_pattern_word(), random_pattern_word(), len);
                end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end && bytes_sent < stop_at) send_region();
            phase++;
        end
    endtask

    // Result receiver: random stall bursts and one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (idle_on && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_search_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (o_found === 1'b1) found_seen++;
            else notfound_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result found=%0b offset=%0d",
                             $time, o_found, o_match_offset);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_found !== exp_res.found || o_match_offset !== exp_res.offset) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch expected found=%0b offset=%0d, ",
                                  "got found=%0b offset=%0d"},
                                 $time, exp_res.found, exp_res.offset, o_found,
                                 o_match_offset);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        pattern     = '0;
        pattern_len = 5'd1;
        clear_region();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_match_and_skip();
        test_short_region();
        test_match_on_last();
        test_empty_pattern();
        test_config_mid_region();
        test_backpressure();
        test_random_regions();
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Searched %0d bytes in %0d regions under %0d pattern settings",
                 bytes_sent, regions_sent, settings_used);
        $display("Results: %0d found, %0d not found, %0d mismatches",
                 found_seen, notfound_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
